// File: hdl/b64e_pkg.sv
package b64e_pkg;

	localparam int HDR_CHARS = 24;
	localparam int JOB_CHARS = 28;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [1:0] {
		REG_RAW_LENGTH     = 2'd0,
		REG_PAYLOAD_LENGTH = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_block;
	} out_word_t;

	typedef struct packed {
		logic        hdr;
		logic        grp;
		logic        last;
		logic [1:0]  n;
		logic [23:0] bytes;
		logic [30:0] raw;
		logic [30:0] pay;
	} job_t;

	typedef struct packed {
		logic valid;
	} q_ctl_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

// File: hdl/b64e_front.sv
module b64e_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  b64e_pkg::in_word_t in_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               q_full,
	output logic               q_push,
	output b64e_pkg::job_t     q_job
);
	import b64e_pkg::*;

	logic [30:0] raw_q;
	logic [30:0] pay_q;
	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        hdr_sent_q;

	logic        accept;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [1:0]  cnt_next;
	logic        grp;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		b0 = in_word.data_byte;
		b1 = 8'h00;
		b2 = 8'h00;
		unique case (cnt_q)
			2'd0: begin
				b0 = in_word.data_byte;
			end
			2'd1: begin
				b0 = pend_q[15:8];
				b1 = in_word.data_byte;
			end
			default: begin
				b0 = pend_q[15:8];
				b1 = pend_q[7:0];
				b2 = in_word.data_byte;
			end
		endcase
	end

	assign cnt_next = (cnt_q == 2'd3) ? 2'd3 : ((cnt_q > 2'd2) ? 2'd3 : cnt_q + 2'd1);
	assign grp      = (cnt_next == 2'd3) || in_word.is_final;

	assign q_push      = accept && (grp || !hdr_sent_q);
	assign q_job.hdr   = !hdr_sent_q;
	assign q_job.grp   = grp;
	assign q_job.last  = in_word.is_final;
	assign q_job.n     = cnt_next;
	assign q_job.bytes = {b0, b1, b2};
	assign q_job.raw   = raw_q;
	assign q_job.pay   = pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q      <= '0;
			pay_q      <= '0;
			pend_q     <= '0;
			cnt_q      <= '0;
			hdr_sent_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RAW_LENGTH) begin
					raw_q <= cfg_data[30:0];
				end else if (cfg_index == REG_PAYLOAD_LENGTH) begin
					pay_q <= cfg_data[30:0];
				end
			end
			if (accept) begin
				if (grp) begin
					pend_q <= '0;
					cnt_q  <= '0;
				end else begin
					pend_q <= {b0, b1};
					cnt_q  <= cnt_next;
				end
				hdr_sent_q <= !in_word.is_final;
			end
		end
	end

endmodule

// File: hdl/b64e_queue.sv
module b64e_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64e_pkg::job_t        push_job,
	output logic                  full,
	output b64e_pkg::q_ctl_t      ctl_out,
	input  logic                  pop,
	output b64e_pkg::job_t        head_job
);
	import b64e_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full          = (cnt_q == CW'(DEPTH));
	assign ctl_out.valid = (cnt_q != '0);
	assign head_job      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/b64e_back.sv
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64e_pkg::q_ctl_t    q_ctl,
	input  b64e_pkg::job_t      head_job,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output b64e_pkg::out_word_t out_word
);
	import b64e_pkg::*;

	job_t        job_q;
	logic        busy_q;
	logic [4:0]  pos_q;
	logic        out_valid_q;
	out_word_t   out_word_q;

	logic         adv;
	logic         last_char;
	logic [143:0] hs;
	logic [143:0] hsh;
	logic [23:0]  gsh;
	logic [1:0]   gi;
	logic [5:0]   sextet;
	logic         pad;
	out_word_t    nxt;

	function automatic logic [31:0] le32(input logic [30:0] x);
		return {x[7:0], x[15:8], x[23:16], 1'b0, x[30:24]};
	endfunction

	assign adv       = !out_valid_q || !out_stall;
	assign q_pop     = !busy_q && q_ctl.valid;
	assign last_char = (pos_q == 5'(JOB_CHARS - 1)) ||
	                   ((pos_q == 5'(HDR_CHARS - 1)) && !job_q.grp);
	assign gi        = pos_q[1:0];

	always_comb begin
		hs  = {32'h01000000, le32(job_q.raw), le32(job_q.raw), le32(job_q.pay), 16'h0000};
		hsh = hs << (8'(pos_q) * 8'd6);
		gsh = job_q.bytes << (5'(gi) * 5'd6);
		if (pos_q < 5'(HDR_CHARS)) begin
			sextet = hsh[143:138];
			pad    = (pos_q >= 5'(HDR_CHARS - 2));
		end else begin
			sextet = gsh[23:18];
			pad    = ((gi == 2'd2) && (job_q.n < 2'd2)) ||
			         ((gi == 2'd3) && (job_q.n < 2'd3));
		end
		nxt.out_char     = pad ? PAD_CHAR : b64_char(sextet);
		nxt.end_of_block = (pos_q == 5'(JOB_CHARS - 1)) && job_q.last;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= head_job;
		end
		if (adv && busy_q) begin
			out_word_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				pos_q  <= head_job.hdr ? 5'd0 : 5'(HDR_CHARS);
			end else if (busy_q && adv) begin
				pos_q <= pos_q + 5'd1;
				if (last_char) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: hdl/base64_header_block_encoder_core.sv
// A word's bytes are written to the job queue, then to the back's job register, and each
// character in the output register. One character per cycle while out_stall is low;
// a job is taken only after the last ends; a group gives 4 characters, the header 24.
// Input stalls only while the job queue between front and back is full.
// arst_n clears queue, grouping state, header flag, registers and output valid.
module base64_header_block_encoder_core #(
	parameter int QDEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  b64e_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output b64e_pkg::out_word_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import b64e_pkg::*;

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	job_t   push_job;
	job_t   head_job;
	q_ctl_t q_ctl;

	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	b64e_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.ctl_out  (q_ctl),
		.pop      (q_pop),
		.head_job (head_job)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_ctl     (q_ctl),
		.head_job  (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// File: hdl/b64e_checker.sv
module b64e_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input b64e_pkg::out_word_t out_word
);
	import b64e_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.out_char >= 8'h2B) && (out_word.out_char <= 8'h7A))
		else $error("output character outside base64 range");

	a_new_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_word.end_of_block |=>
			!out_valid || (out_word.out_char == 8'h41))
		else $error("block after end of block does not open with header");

endmodule

bind base64_header_block_encoder_core b64e_checker u_b64e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// File: tb/testbench.sv
module testbench;
	import b64e_pkg::*;

	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int DIR_ROWS = 23;
	localparam int RANDOM_BYTES = 500;
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_FIRST = 150;
	localparam int QUIET_LAST = 300;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        fin;
		logic        typed;
		logic [31:0] raw;
		logic [31:0] pay;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic [30:0] hdr_raw_len = '0;
	logic [30:0] hdr_pay_len = '0;
	logic [15:0] held_bytes = '0;
	logic [1:0]  held_count = '0;
	logic        header_done = 1'b0;

	out_word_t step_chars[$];
	out_word_t expected_chars[$];
	int        fail_count = 0;
	bit        quiet = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_CFG,  8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_CFG,  8'h00, 1'b0, 1'b0, 32'h0, 32'h7FFF_FFFF},
		'{ROW_BYTE, 8'h4D, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h61, 1'b0, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h6E, 1'b1, 1'b1, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hAA, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_CFG,  8'h00, 1'b0, 1'b0, 32'h1234_5678, 32'h0BAD_F00D},
		'{ROW_BYTE, 8'h55, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h0F, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h01, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h7F, 1'b1, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hC3, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h3C, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'h5A, 1'b0, 1'b0, 32'h0, 32'h0},
		'{ROW_BYTE, 8'hA5, 1'b1, 1'b0, 32'h0, 32'h0}
	};

	string dir_text [DIR_ROWS] = '{
		"AQAAAAAAAAAAAAAAAAAAAA==AA==",
		"AQAAAAAAAAAAAAAAAAAAAA==/w==",
		"", "", "", "////", "", "AAA=", "", "", "", "TWFu",
		"", "", "", "", "", "", "", "", "", "", ""
	};

	base64_header_block_encoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic void push_group(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input int n, input logic last);
		logic [23:0] g;
		logic [7:0]  c2;
		logic [7:0]  c3;
		g = {b0, b1, b2};
		c2 = (n >= 2) ? b64_alpha[int'(g[11:6])] : PAD_CHAR;
		c3 = (n >= 3) ? b64_alpha[int'(g[5:0])] : PAD_CHAR;
		step_chars.push_back('{out_char: b64_alpha[int'(g[23:18])], end_of_block: 1'b0});
		step_chars.push_back('{out_char: b64_alpha[int'(g[17:12])], end_of_block: 1'b0});
		step_chars.push_back('{out_char: c2, end_of_block: 1'b0});
		step_chars.push_back('{out_char: c3, end_of_block: last});
	endfunction

	function automatic void encode_byte(input in_word_t w);
		logic [127:0] hdr;
		logic [7:0]   b0;
		logic [7:0]   b1;
		logic [7:0]   b2;
		int           n;
		step_chars.delete();
		if (!header_done) begin
			hdr = {1'b0, hdr_pay_len, 1'b0, hdr_raw_len, 1'b0, hdr_raw_len, 32'd1};
			for (int g = 0; g < 5; g++)
				push_group(hdr[24*g +: 8], hdr[24*g+8 +: 8], hdr[24*g+16 +: 8], 3, 1'b0);
			push_group(hdr[120 +: 8], 8'h00, 8'h00, 1, 1'b0);
			header_done = 1'b1;
		end
		b0 = (held_count == 2'd0) ? w.data_byte : held_bytes[15:8];
		b1 = (held_count == 2'd0) ? 8'h00 : (held_count == 2'd1) ? w.data_byte : held_bytes[7:0];
		b2 = (held_count == 2'd2) ? w.data_byte : 8'h00;
		n = int'(held_count) + 1;
		if (n == 3 || w.is_final) begin
			push_group(b0, b1, b2, n, w.is_final);
			held_bytes = '0;
			held_count = '0;
		end else begin
			held_bytes = {b0, b1};
			held_count = 2'(n);
		end
		if (w.is_final)
			header_done = 1'b0;
	endfunction

	task automatic check_char(input out_word_t got);
		out_word_t want;
		if (expected_chars.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected char %h eob %b", got.out_char, got.end_of_block);
			fail_count++;
		end else begin
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char || got.end_of_block !== want.end_of_block) begin
				if (fail_count < 10)
					$display("char mismatch: expected %h eob %b, got %h eob %b",
						want.out_char, want.end_of_block, got.out_char, got.end_of_block);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_char(out_word);
		out_stall <= !quiet && ($urandom_range(0, 99) < 16);
	end

	task automatic push_byte(input logic [7:0] data, input logic fin, input logic typed,
		input string text);
		in_word_t w;
		w.data_byte = data;
		w.is_final = fin;
		encode_byte(w);
		if (typed) begin
			for (int i = 0; i < text.len(); i++)
				expected_chars.push_back('{out_char: text[i],
					end_of_block: fin && (i == text.len() - 1)});
		end else begin
			foreach (step_chars[i])
				expected_chars.push_back(step_chars[i]);
		end
		while (!quiet && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		// let a held byte settle in the block
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_RAW_LENGTH: begin
				hdr_raw_len = val[30:0];
			end
			REG_PAYLOAD_LENGTH: begin
				hdr_pay_len = val[30:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic config_phase(input logic [31:0] raw, input logic [31:0] pay);
		drain();
		write_reg(REG_RAW_LENGTH, raw);
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		write_reg(REG_PAYLOAD_LENGTH, pay);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_length();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = 32'h0000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'hFFFF_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		int sent;
		int blen;
		int pick;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG)
				config_phase(dir_rows[r].raw, dir_rows[r].pay);
			else
				push_byte(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].typed, dir_text[r]);
		end
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 3) == 0)
				config_phase(pick_length(), pick_length());
			pick = $urandom_range(0, 9);
			if (pick < 3)
				blen = 1;
			else if (pick < 8)
				blen = $urandom_range(2, 12);
			else if (pick == 8)
				blen = $urandom_range(13, 40);
			else
				blen = $urandom_range(2, 5);
			for (int i = 0; i < blen; i++) begin
				quiet = (sent >= QUIET_FIRST && sent < QUIET_LAST);
				push_byte(8'($urandom_range(0, 255)), i == blen - 1, 1'b0, "");
				sent++;
			end
		end
		quiet = 1'b0;
		drain();
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
